### rtl/rbbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range bounded bit packer package
// Shared types and constants: item layouts, command and status codes, sizes.
// ----------------------------------------------------------------------------
package rbbp_pkg;

    // Upper limit of the destination buffer in 32-bit words.
    localparam int MAX_WORDS = 1024;

    localparam int WORD_W   = 32;
    localparam int BUFW_W   = 11;   // buffer_words register and slot counter
    localparam int INDEX_W  = 10;   // reported slot index
    localparam int COUNT_W  = 5;    // bits held between items, 0..31
    localparam int FWIDTH_W = 6;    // field width, 0..32
    localparam int TOTAL_W  = 16;   // bit total since restart

    localparam logic [BUFW_W-1:0] BUF_WORDS_RESET = BUFW_W'(1024);

    // The effective capacity is min(buffer_words, MAX_WORDS). A limit beyond
    // what the register can express never clips, so it saturates here.
    localparam logic [BUFW_W-1:0] MAX_WORDS_CAP =
        (MAX_WORDS > (2**BUFW_W - 1)) ? {BUFW_W{1'b1}} : BUFW_W'(MAX_WORDS);

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_FLUSH   = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] min_value;
        logic [WORD_W-1:0] max_value;
    } in_item_t;

    typedef struct packed {
        logic               word_valid;
        logic [WORD_W-1:0]  word_out;
        logic [INDEX_W-1:0] word_index;
        logic [1:0]         status;
        logic               sticky_overflow;
        logic [TOTAL_W-1:0] bits_written;
    } out_item_t;

endpackage
`default_nettype wire

### rtl/rbbp_width.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range bounded bit packer field width
// Computes floor(log2(max - min)) + 1, or zero when min equals max.
// ----------------------------------------------------------------------------
module rbbp_width (
    input  wire logic [rbbp_pkg::WORD_W-1:0]   min_value,
    input  wire logic [rbbp_pkg::WORD_W-1:0]   max_value,
    output logic      [rbbp_pkg::FWIDTH_W-1:0] width
);
    import rbbp_pkg::*;

    logic [WORD_W-1:0]   span;
    logic [FWIDTH_W-1:0] msb_plus_one;

    assign span = max_value - min_value;

    // Leading-one detector: the highest set bit wins.
    always_comb begin
        msb_plus_one = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (span[i]) begin
                msb_plus_one = FWIDTH_W'(i + 1);
            end
        end
    end

    assign width = (min_value == max_value) ? '0 : msb_plus_one;

endmodule
`default_nettype wire

### rtl/range_bounded_bit_packer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range bounded bit packer
// Packs range-bounded integers LSB first into consecutive 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item on the s_ channel carries a command (write, flush or
//   restart) and, for a write, a value with its inclusive range. A write
//   appends (value - min_value) in floor(log2(max - min)) + 1 bits; a flush
//   emits any partial word; a restart clears the packing state.
//   Every input item produces exactly one result item on the m_ channel,
//   which reports the emitted word (if any), its slot, a status code, the
//   sticky overflow flag and the running bit total.
//   The accepting edge loads the input register, and the result register
//   loads from it when the output advances, raising m_valid. Throughput is one
//   item per cycle unless the receiver stalls; width detection, the 64-bit
//   shift/merge and the capacity compare sit in the single stage between them.
//   When the receiver stalls, the result register holds its item, the input
//   register takes one more item, and s_ready then drops until m_ready
//   returns; nothing is dropped or repeated.
//   Reset (aresetn low, synchronous) empties both registers, clears the
//   scratch word, counters and overflow flag, and sets buffer_words to 1024.
//   buffer_words is written through cfg_wr_en/cfg_wr_data and is expected to
//   change only while no item is in flight.
// ----------------------------------------------------------------------------
module range_bounded_bit_packer (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire rbbp_pkg::in_item_t         s_data,

    output logic                            m_valid,
    input  wire logic                       m_ready,
    output rbbp_pkg::out_item_t             m_data,

    input  wire logic                       cfg_wr_en,
    input  wire logic [rbbp_pkg::BUFW_W-1:0] cfg_wr_data
);
    import rbbp_pkg::*;

    // Configuration register.
    logic [BUFW_W-1:0] buf_words_reg;

    // Pipeline registers.
    logic      inp_valid_reg;
    in_item_t  inp_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    // Packing state. Between items fewer than 32 bits are ever held, so the
    // scratch register keeps just one word and a five-bit count.
    logic [WORD_W-1:0]  scratch_reg,   scratch_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic [BUFW_W-1:0]  slot_reg,      slot_next;
    logic [TOTAL_W-1:0] total_reg,     total_next;
    logic               overflow_reg,  overflow_next;

    // Handshake and advance control.
    logic advance;
    logic step;

    assign advance = !out_valid_reg || m_ready;
    assign step    = inp_valid_reg && advance;
    assign s_ready = !inp_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // Datapath for the item in the input register.
    logic [FWIDTH_W-1:0]  fwidth;
    logic [BUFW_W-1:0]    cap;
    logic [TOTAL_W:0]     cap_bits;
    logic [TOTAL_W:0]     need_bits;
    logic [FWIDTH_W-1:0]  count_sum;
    logic                 completes;
    logic                 in_range;
    logic                 slots_full;
    logic [WORD_W-1:0]    offset;
    logic [2*WORD_W-1:0]  merged;

    rbbp_width u_width (
        .min_value (inp_item_reg.min_value),
        .max_value (inp_item_reg.max_value),
        .width     (fwidth)
    );

    assign cap        = (buf_words_reg < MAX_WORDS_CAP) ? buf_words_reg : MAX_WORDS_CAP;
    assign cap_bits   = {1'b0, cap, 5'b0};
    assign need_bits  = {1'b0, total_reg} + (TOTAL_W + 1)'(fwidth);
    assign count_sum  = {1'b0, count_reg} + fwidth;
    assign completes  = count_sum[FWIDTH_W-1];
    assign slots_full = (slot_reg >= cap);
    assign in_range   = (inp_item_reg.value >= inp_item_reg.min_value) &&
                        (inp_item_reg.value <= inp_item_reg.max_value);

    // A value inside its range already fits in the field width, so the
    // offset needs no mask before it is merged above the held bits.
    assign offset = inp_item_reg.value - inp_item_reg.min_value;
    assign merged = {{WORD_W{1'b0}}, scratch_reg} | ({{WORD_W{1'b0}}, offset} << count_reg);

    always_comb begin
        scratch_next  = scratch_reg;
        count_next    = count_reg;
        slot_next     = slot_reg;
        total_next    = total_reg;
        overflow_next = overflow_reg;

        out_item_next                 = '0;
        out_item_next.status          = ST_OK;

        case (cmd_t'(inp_item_reg.cmd))
            CMD_WRITE: begin
                if (!in_range) begin
                    out_item_next.status = ST_RANGE;
                end else if ((need_bits > cap_bits) || (completes && slots_full)) begin
                    out_item_next.status = ST_OVERFLOW;
                    overflow_next        = 1'b1;
                end else if (fwidth != '0) begin
                    total_next = total_reg + TOTAL_W'(fwidth);
                    if (completes) begin
                        out_item_next.word_valid = 1'b1;
                        out_item_next.word_out   = merged[WORD_W-1:0];
                        out_item_next.word_index = slot_reg[INDEX_W-1:0];
                        slot_next    = slot_reg + BUFW_W'(1);
                        scratch_next = merged[2*WORD_W-1:WORD_W];
                    end else begin
                        scratch_next = merged[WORD_W-1:0];
                    end
                    count_next = count_sum[COUNT_W-1:0];
                end
            end
            CMD_FLUSH: begin
                if (count_reg != '0) begin
                    if (slots_full) begin
                        out_item_next.status = ST_OVERFLOW;
                        overflow_next        = 1'b1;
                    end else begin
                        out_item_next.word_valid = 1'b1;
                        out_item_next.word_out   = scratch_reg;
                        out_item_next.word_index = slot_reg[INDEX_W-1:0];
                        slot_next = slot_reg + BUFW_W'(1);
                    end
                    scratch_next = '0;
                    count_next   = '0;
                end
            end
            CMD_RESTART: begin
                scratch_next  = '0;
                count_next    = '0;
                slot_next     = '0;
                total_next    = '0;
                overflow_next = 1'b0;
            end
            default: begin
                // Unused command code: no state change, status ok.
            end
        endcase

        out_item_next.sticky_overflow = overflow_next;
        out_item_next.bits_written    = total_next;
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_words_reg <= BUF_WORDS_RESET;
            inp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            scratch_reg   <= '0;
            count_reg     <= '0;
            slot_reg      <= '0;
            total_reg     <= '0;
            overflow_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                buf_words_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                inp_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= inp_valid_reg;
            end
            if (step) begin
                scratch_reg  <= scratch_next;
                count_reg    <= count_next;
                slot_reg     <= slot_next;
                total_reg    <= total_next;
                overflow_reg <= overflow_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            inp_item_reg <= s_data;
        end
        if (step) begin
            out_item_reg <= out_item_next;
        end
    end

endmodule
`default_nettype wire
